// ----- rtl/saifda_pkg.sv -----
`timescale 1ns / 1ps

package saifda_pkg;

  localparam int unsigned ModeW = 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 8;
  localparam int unsigned StatW = 2;

  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_DELETE = 2'd1;
  localparam logic [ModeW-1:0] MODE_READ   = 2'd2;
  localparam logic [ModeW-1:0] MODE_NONE   = 2'd3;

  localparam logic [StatW-1:0] ST_OK     = 2'd0;
  localparam logic [StatW-1:0] ST_FULL   = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY  = 2'd2;
  localparam logic [StatW-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
  } op_t;

endpackage

// ----- rtl/saifda_front.sv -----
`timescale 1ns / 1ps

// Accepts items, drops the unused mode, and holds up to two commands for the back end.
module saifda_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [saifda_pkg::ModeW-1:0]           mode_i,
  input  logic signed [saifda_pkg::DataW-1:0]    value_i,
  input  logic [saifda_pkg::PosW-1:0]            position_i,
  output logic                                   q_valid_o,
  output saifda_pkg::op_t                        q_op_o,
  input  logic                                   q_pop_i
);

  saifda_pkg::op_t ent_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && (mode_i != saifda_pkg::MODE_NONE);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_op_o     = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (q_pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= '{mode: mode_i, value: value_i, position: position_i};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");

  a_drop_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && mode_i == saifda_pkg::MODE_NONE && !q_pop_i)
      |=> $stable(cnt_q)) else $error("unused mode entered the queue");

endmodule

// ----- rtl/saifda_back.sv -----
`timescale 1ns / 1ps

// Executes queued commands on the shift array and drives the result register.
module saifda_back #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  saifda_pkg::op_t                     q_op_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [saifda_pkg::StatW-1:0]        status_o,
  output logic signed [saifda_pkg::DataW-1:0] data_o,
  output logic                                last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [saifda_pkg::DataW-1:0] elem_q [DEPTH];
  logic [saifda_pkg::DataW-1:0] elem_d [DEPTH];
  logic [CW-1:0]                count_q, count_d;
  logic                         busy_q, busy_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic                         out_valid_q, out_valid_d;
  logic                         load;
  logic [saifda_pkg::StatW-1:0] status_q, status_d;
  logic [saifda_pkg::DataW-1:0] data_q, data_d;
  logic                         last_q, last_d;
  logic                         out_free;
  logic [IW-1:0]                del_idx;
  logic [saifda_pkg::PosW-1:0]  count_ext;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign del_idx   = IW'(q_op_i.position - saifda_pkg::PosW'(1));
  assign count_ext = saifda_pkg::PosW'(count_q);

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign last_o      = last_q;

  always_comb begin
    elem_d      = elem_q;
    count_d     = count_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    load        = 1'b0;
    status_d    = saifda_pkg::ST_OK;
    data_d      = '0;
    last_d      = 1'b1;
    q_pop_o     = 1'b0;

    if (busy_q) begin
      // read-out in progress, one element per transfer
      if (out_free) begin
        load   = 1'b1;
        data_d = elem_q[idx_q];
        last_d = (CW'(idx_q) + CW'(1) == count_q);
        if (last_d) begin
          busy_d  = 1'b0;
          q_pop_o = 1'b1;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
    end else if (q_valid_i && out_free) begin
      load    = 1'b1;
      q_pop_o = 1'b1;
      case (q_op_i.mode)
        saifda_pkg::MODE_INSERT: begin
          if (count_q == CW'(DEPTH)) begin
            status_d = saifda_pkg::ST_FULL;
          end else begin
            for (int j = DEPTH - 1; j > 0; j--) begin
              elem_d[j] = elem_q[j-1];
            end
            elem_d[0] = q_op_i.value;
            count_d   = count_q + CW'(1);
          end
        end
        saifda_pkg::MODE_DELETE: begin
          if (count_q == '0) begin
            status_d = saifda_pkg::ST_EMPTY;
          end else if (q_op_i.position == '0 || q_op_i.position > count_ext) begin
            status_d = saifda_pkg::ST_BADPOS;
          end else begin
            data_d = elem_q[del_idx];
            for (int j = 0; j < DEPTH - 1; j++) begin
              if (j >= int'(del_idx)) begin
                elem_d[j] = elem_q[j+1];
              end
            end
            count_d = count_q - CW'(1);
          end
        end
        saifda_pkg::MODE_READ: begin
          if (count_q == '0) begin
            status_d = saifda_pkg::ST_EMPTY;
          end else begin
            data_d = elem_q[0];
            if (count_q != CW'(1)) begin
              last_d  = 1'b0;
              q_pop_o = 1'b0;
              busy_d  = 1'b1;
              idx_d   = IW'(1);
            end
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    if (load) begin
      status_q <= status_d;
      data_q   <= data_d;
      last_q   <= last_d;
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("count above depth");

  a_busy_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (count_q != '0 && CW'(idx_q) < count_q)) else $error("read index out of range");

  a_busy_holds_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> q_valid_i) else $error("read-out without a queued command");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_pop_o |=> $stable(count_q)) else $error("count changed without a command");

endmodule

// ----- rtl/shift_array_insert_front_delete_at.sv -----
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values, front at position 1.
// Input channel (in_valid_i / in_stall_o): mode_i, value_i, position_i.
//   mode 0 inserts value_i at the front, mode 1 deletes the 1-based entry at
//   position_i, mode 2 reads the list out front to back, mode 3 is dropped.
// Output channel (out_valid_o / out_stall_i): status_o, data_o, last_o.
//   Insert and delete give one result; read-out gives one per element with
//   last_o on the final one; errors give a single result with data_o zero.
// A transfer lands in a two-entry command queue; the executing side takes it
// from the queue once the result register is free and loads its result there.
// Insert and delete finish as they are taken; read-out passes one element per
// transfer through the result register and keeps its command queued until the
// last one, so sustained rate is one item per cycle except read-out and stalls.
// When the receiver stalls, the result holds and the queue fills; the input
// stalls once both queue entries are in use.
// Reset empties the list and the queue; list contents are not cleared.
module shift_array_insert_front_delete_at #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [saifda_pkg::ModeW-1:0]        mode_i,
  input  logic signed [saifda_pkg::DataW-1:0] value_i,
  input  logic [saifda_pkg::PosW-1:0]         position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [saifda_pkg::StatW-1:0]        status_o,
  output logic signed [saifda_pkg::DataW-1:0] data_o,
  output logic                                last_o
);

  logic            q_valid;
  logic            q_pop;
  saifda_pkg::op_t q_op;

  saifda_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .position_i (position_i),
    .q_valid_o  (q_valid),
    .q_op_o     (q_op),
    .q_pop_i    (q_pop)
  );

  saifda_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

endmodule

// ----- tb/shift_array_insert_front_delete_at_tb.sv -----
`timescale 1ns / 1ps

module shift_array_insert_front_delete_at_tb;

  localparam int unsigned Depth     = 8;
  localparam int unsigned NumOps    = 385;
  localparam int unsigned MaxCycles = 200000;

  typedef struct packed {
    logic [saifda_pkg::StatW-1:0]        status;
    logic signed [saifda_pkg::DataW-1:0] data;
    logic                                last;
  } result_t;

  // Mirror of the list contents plus the results still owed by the block.
  class list_tracker;
    logic signed [saifda_pkg::DataW-1:0] slots[Depth];
    int unsigned                         fill;
    result_t                             pending_results[$];
    int unsigned                         errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void owe(logic [saifda_pkg::StatW-1:0] status,
                      logic signed [saifda_pkg::DataW-1:0] data, logic last);
      result_t r;
      r.status = status;
      r.data   = data;
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_op(logic [saifda_pkg::ModeW-1:0] mode,
                          logic signed [saifda_pkg::DataW-1:0] value,
                          logic [saifda_pkg::PosW-1:0] pos);
      int unsigned k;
      case (mode)
        saifda_pkg::MODE_INSERT: begin
          if (fill >= Depth) begin
            owe(saifda_pkg::ST_FULL, '0, 1'b1);
          end else begin
            for (k = fill; k > 0; k--) slots[k] = slots[k-1];
            slots[0] = value;
            fill++;
            owe(saifda_pkg::ST_OK, '0, 1'b1);
          end
        end
        saifda_pkg::MODE_DELETE: begin
          if (fill == 0) begin
            owe(saifda_pkg::ST_EMPTY, '0, 1'b1);
          end else if (pos == 0 || pos > fill) begin
            owe(saifda_pkg::ST_BADPOS, '0, 1'b1);
          end else begin
            owe(saifda_pkg::ST_OK, slots[pos-1], 1'b1);
            for (k = pos - 1; k + 1 < fill; k++) slots[k] = slots[k+1];
            fill--;
          end
        end
        saifda_pkg::MODE_READ: begin
          if (fill == 0) begin
            owe(saifda_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            for (k = 0; k < fill; k++) owe(saifda_pkg::ST_OK, slots[k], k + 1 == fill);
          end
        end
        default: ; // unused mode is dropped by the block
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [saifda_pkg::StatW-1:0] status,
                      logic signed [saifda_pkg::DataW-1:0] data, logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result status %0d data %0d last %0b", status, data, last));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
        if (data !== want.data)
          report($sformatf("data %0d, expected %0d", data, want.data));
        if (last !== want.last)
          report($sformatf("last %0b, expected %0b", last, want.last));
      end
    endtask
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic [saifda_pkg::ModeW-1:0]        mode_i;
  logic signed [saifda_pkg::DataW-1:0] value_i;
  logic [saifda_pkg::PosW-1:0]         position_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic [saifda_pkg::StatW-1:0]        status_o;
  logic signed [saifda_pkg::DataW-1:0] data_o;
  logic                                last_o;

  list_tracker sb;
  bit          calm;
  int unsigned cycles;

  shift_array_insert_front_delete_at #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .data_o     (data_o),
    .last_o     (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("shift_array_insert_front_delete_at verification failed");
      $finish;
    end
  end

  // Receiver: checks each output transfer, stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(status_o, data_o, last_o);
      out_stall_i <= !calm && ($urandom_range(99) < 20);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_op(logic [saifda_pkg::ModeW-1:0] mode,
                         logic signed [saifda_pkg::DataW-1:0] value,
                         logic [saifda_pkg::PosW-1:0] pos);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_op(mode, value, pos);
  endtask

  task automatic send_insert(logic signed [saifda_pkg::DataW-1:0] value);
    send_op(saifda_pkg::MODE_INSERT, value, saifda_pkg::PosW'($urandom()));
  endtask

  task automatic send_delete(logic [saifda_pkg::PosW-1:0] pos);
    send_op(saifda_pkg::MODE_DELETE, $urandom(), pos);
  endtask

  task automatic send_read();
    send_op(saifda_pkg::MODE_READ, $urandom(), saifda_pkg::PosW'($urandom()));
  endtask

  initial begin
    int unsigned                         sent;
    int unsigned                         pick;
    logic [saifda_pkg::PosW-1:0]         pos;
    logic signed [saifda_pkg::DataW-1:0] value;

    sb          = new();
    calm        = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = saifda_pkg::MODE_INSERT;
    value_i     = '0;
    position_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty cases, extremes of value, full list, bad positions.
    send_read();
    send_delete(8'd1);
    send_op(saifda_pkg::MODE_NONE, $urandom(), saifda_pkg::PosW'($urandom()));
    send_insert(32'sh7fffffff);
    send_insert(32'sh80000000);
    send_insert('0);
    send_insert(-32'sd1);
    send_insert(32'sh55555555);
    send_insert(32'shaaaaaaaa);
    send_insert(32'sd1);
    send_insert(32'sd12345);
    send_insert(32'sd7);
    send_read();
    send_delete(8'd0);
    send_delete(8'd9);
    send_delete(8'd255);
    send_delete(8'd8);
    send_delete(8'd1);
    send_delete(8'd3);
    send_read();
    send_op(saifda_pkg::MODE_NONE, $urandom(), saifda_pkg::PosW'($urandom()));
    send_insert(32'sd42);
    send_read();

    sent = 0;
    while (sent < NumOps) begin
      calm = (sent >= 150 && sent < 280);
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_op(saifda_pkg::MODE_NONE, $urandom(), saifda_pkg::PosW'($urandom()));
      end else if (pick < 47) begin
        case ($urandom_range(9))
          0:       value = 32'sh7fffffff;
          1:       value = 32'sh80000000;
          default: value = $urandom();
        endcase
        send_insert(value);
        sent++;
      end else if (pick < 87) begin
        // mostly in-range positions so deletes get past the checks
        if ($urandom_range(9) == 0 || sb.fill == 0) begin
          pos = saifda_pkg::PosW'($urandom_range(255));
        end else begin
          pos = saifda_pkg::PosW'($urandom_range(sb.fill, 1));
        end
        send_delete(pos);
        sent++;
      end else begin
        send_read();
        sent++;
      end
    end

    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("shift_array_insert_front_delete_at verification clean");
    end else begin
      $display("shift_array_insert_front_delete_at verification failed");
    end
    $finish;
  end

endmodule

// ----- shift_array_insert_front_delete_at.f -----
rtl/saifda_pkg.sv
rtl/saifda_front.sv
rtl/saifda_back.sv
rtl/shift_array_insert_front_delete_at.sv
tb/shift_array_insert_front_delete_at_tb.sv
